/* rtl/itar_pkg.sv */
`default_nettype none
package itar_pkg;

   localparam int VALUE_PORT_W        = 64;
   localparam int VALUE_WIDTH_DEFAULT = 64;
   localparam int QUEUE_DEPTH         = 2;

   localparam logic [2:0] FMT_UDEC = 3'd0;
   localparam logic [2:0] FMT_OCT  = 3'd1;
   localparam logic [2:0] FMT_LHEX = 3'd2;
   localparam logic [2:0] FMT_UHEX = 3'd3;
   localparam logic [2:0] FMT_SDEC = 3'd4;

   localparam logic [1:0] KIND_DEC = 2'd0;
   localparam logic [1:0] KIND_OCT = 2'd1;
   localparam logic [1:0] KIND_HEX = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic       upper;
   } job_ctrl_type;

   function automatic logic [6:0] digit_ascii(input logic [3:0] d, input logic upper);
      logic [6:0] base;
      if (d < 4'd10) begin
         return 7'h30 + {3'b000, d};
      end
      base = upper ? 7'h41 : 7'h61;
      return base + {3'b000, d} - 7'd10;
   endfunction

endpackage
`default_nettype wire

/* rtl/itar_front.sv */
`default_nettype none
module itar_front #(
   parameter int VALUE_WIDTH = itar_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [itar_pkg::VALUE_PORT_W-1:0] req_value,
   input  wire logic [2:0]                        req_format,
   input  wire logic                              queue_full,
   output logic                                   push,
   output logic [VALUE_WIDTH-1:0]                 job_mag,
   output itar_pkg::job_ctrl_type                 job_ctrl
);
   import itar_pkg::*;

   logic [VALUE_WIDTH-1:0] raw;

   assign raw       = req_value[VALUE_WIDTH-1:0];
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      job_ctrl.upper = 1'b0;
      unique case (req_format) inside
         FMT_OCT:            job_ctrl.kind = KIND_OCT;
         FMT_LHEX, FMT_UHEX: job_ctrl.kind = KIND_HEX;
         default:            job_ctrl.kind = KIND_DEC;
      endcase
      if (req_format == FMT_UHEX) begin
         job_ctrl.upper = 1'b1;
      end
   end

   // signed decimal: convert the two's complement magnitude
   assign job_mag = (req_format == FMT_SDEC && raw[VALUE_WIDTH-1]) ? (~raw + 1'b1) : raw;

endmodule
`default_nettype wire

/* rtl/itar_queue.sv */
`default_nettype none
module itar_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = itar_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic [DATA_W-1:0]      pop_data,
   output logic                   not_empty
);
   import itar_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* rtl/itar_back.sv */
`default_nettype none
module itar_back #(
   parameter int VALUE_WIDTH = itar_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   job_valid,
   output logic                        job_pop,
   input  wire logic [VALUE_WIDTH-1:0] job_mag,
   input  wire itar_pkg::job_ctrl_type job_ctrl,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [6:0]                  rsp_digit_char,
   output logic                        rsp_last
);
   import itar_pkg::*;

   localparam int DEC_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
   localparam int OCT_DIGITS = (VALUE_WIDTH + 2) / 3;
   localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
   localparam int MAX_DIGITS = OCT_DIGITS;
   localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DABBLE = 2'd1;
   localparam logic [1:0] ST_COUNT  = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [MAX_DIGITS-1:0][3:0]  digits_ff, digits_in;
   logic [VALUE_WIDTH-1:0]      shift_ff, shift_in;
   logic [CNT_W-1:0]            bitcnt_ff, bitcnt_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic                        upper_ff, upper_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [6:0]                  rsp_char_ff, rsp_char_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [DEC_DIGITS-1:0][3:0]  adj;
   logic [OCT_DIGITS*3-1:0]     oct_ext;
   logic [HEX_DIGITS*4-1:0]     hex_ext;
   logic [IDX_W-1:0]            top_idx;
   logic                        out_free;

   assign oct_ext  = (OCT_DIGITS*3)'(job_mag);
   assign hex_ext  = (HEX_DIGITS*4)'(job_mag);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;

   // double dabble add-3 correction
   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         adj[i] = (digits_ff[i] >= 4'd5) ? digits_ff[i] + 4'd3 : digits_ff[i];
      end
   end

   // most significant nonzero digit, zero gives one digit
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (digits_ff[i] != 4'd0) begin
            top_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      digits_in    = digits_ff;
      shift_in     = shift_ff;
      bitcnt_in    = bitcnt_ff;
      idx_in       = idx_ff;
      upper_in     = upper_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      job_pop      = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop   = 1'b1;
               upper_in  = job_ctrl.upper;
               digits_in = '0;
               case (job_ctrl.kind)
                  KIND_OCT: begin
                     for (int i = 0; i < OCT_DIGITS; i++) begin
                        digits_in[i] = {1'b0, oct_ext[3*i +: 3]};
                     end
                     state_in = ST_COUNT;
                  end
                  KIND_HEX: begin
                     for (int i = 0; i < HEX_DIGITS; i++) begin
                        digits_in[i] = hex_ext[4*i +: 4];
                     end
                     state_in = ST_COUNT;
                  end
                  default: begin
                     shift_in  = job_mag;
                     bitcnt_in = CNT_W'(VALUE_WIDTH);
                     state_in  = ST_DABBLE;
                  end
               endcase
            end
         end
         ST_DABBLE: begin
            digits_in[0] = {adj[0][2:0], shift_ff[VALUE_WIDTH-1]};
            for (int i = 1; i < DEC_DIGITS; i++) begin
               digits_in[i] = {adj[i][2:0], adj[i-1][3]};
            end
            shift_in  = shift_ff << 1;
            bitcnt_in = bitcnt_ff - 1'b1;
            if (bitcnt_ff == CNT_W'(1)) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            idx_in   = top_idx;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_ascii(digits_ff[idx_ff], upper_ff);
               rsp_last_in  = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff   <= digits_in;
      shift_ff    <= shift_in;
      bitcnt_ff   <= bitcnt_in;
      idx_ff      <= idx_in;
      upper_ff    <= upper_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule
`default_nettype wire

/* rtl/integer_to_ascii_radix.sv */
`default_nettype none
// Binary to ASCII digit converter.
// Request channel (req_valid/req_stall): one value plus a format code
// (unsigned decimal, octal, lower hex, upper hex, signed decimal). A transfer
// happens on a clock edge with req_valid high and req_stall low.
// Response channel (rsp_valid/rsp_stall): one ASCII digit per transfer, most
// significant first, no leading zeros, rsp_last set on the final digit.
// Signed decimal emits the magnitude only, without a sign.
// Accepted requests wait in a two-entry queue; the converter takes one at a
// time. Decimal runs a shift-and-add-3 pass over the VALUE_WIDTH bits (64 by
// default), then a count step, then emits one digit per cycle while the
// output is not stalled. Octal and hex skip the shift pass and go straight
// to the count step. Holding rsp_stall freezes the pending digit; the next
// request is still taken while the queue has room. Reset empties the queue
// and drops any conversion in progress.
module integer_to_ascii_radix #(
   parameter int VALUE_WIDTH = itar_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [itar_pkg::VALUE_PORT_W-1:0] req_value,
   input  wire logic [2:0]                        req_format,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [6:0]                             rsp_digit_char,
   output logic                                   rsp_last
);
   import itar_pkg::*;

   localparam int CTRL_W = $bits(job_ctrl_type);
   localparam int DATA_W = VALUE_WIDTH + CTRL_W;

   logic                   queue_full;
   logic                   push;
   logic [VALUE_WIDTH-1:0] push_mag;
   job_ctrl_type           push_ctrl;
   logic                   pop;
   logic                   not_empty;
   logic [DATA_W-1:0]      pop_data;
   logic [VALUE_WIDTH-1:0] pop_mag;
   job_ctrl_type           pop_ctrl;

   itar_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .req_format(req_format),
      .queue_full(queue_full),
      .push      (push),
      .job_mag   (push_mag),
      .job_ctrl  (push_ctrl)
   );

   itar_queue #(
      .DATA_W(DATA_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data({push_ctrl, push_mag}),
      .full     (queue_full),
      .pop      (pop),
      .pop_data (pop_data),
      .not_empty(not_empty)
   );

   assign pop_mag  = pop_data[VALUE_WIDTH-1:0];
   assign pop_ctrl = job_ctrl_type'(pop_data[DATA_W-1:VALUE_WIDTH]);

   itar_back #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (not_empty),
      .job_pop       (pop),
      .job_mag       (pop_mag),
      .job_ctrl      (pop_ctrl),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_digit_char(rsp_digit_char),
      .rsp_last      (rsp_last)
   );

endmodule
`default_nettype wire

/* tb/integer_to_ascii_radix_tb.sv */
`default_nettype none
module integer_to_ascii_radix_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import itar_pkg::*;

   localparam int MAX_DIGITS   = 22;
   localparam int RANDOM_ITEMS = 430;
   localparam int PHASE_ITEMS  = 72;
   localparam int DRAIN_CYCLES = 120;
   localparam int QUIET_LIMIT  = 2000;
   localparam int PRINT_LIMIT  = 200;

   class digit_scoreboard;
      typedef struct packed {
         logic [6:0] ch;
         logic       last;
      } digit_type;

      digit_type digits_due[$];
      int        fail_count;

      function new();
         fail_count = 0;
      endfunction

      // Expand one accepted request into its expected digit transfers.
      function void note_request(logic [VALUE_PORT_W-1:0] value, logic [2:0] fmt);
         logic [VALUE_PORT_W-1:0] mag;
         logic [VALUE_PORT_W-1:0] radix;
         logic [3:0]              found [0:MAX_DIGITS-1];
         int                      n;
         string                   glyphs;
         digit_type               d;
         mag    = value;
         glyphs = "0123456789abcdef";
         case (fmt)
            FMT_OCT:  radix = 64'd8;
            FMT_LHEX: radix = 64'd16;
            FMT_UHEX: begin
               radix  = 64'd16;
               glyphs = "0123456789ABCDEF";
            end
            default:  radix = 64'd10;
         endcase
         if (fmt == FMT_SDEC && mag[VALUE_PORT_W-1])
            mag = -mag;
         n = 0;
         do begin
            found[n] = 4'(mag % radix);
            mag      = mag / radix;
            n++;
         end while (mag != 0 && n < MAX_DIGITS);
         for (int k = n - 1; k >= 0; k--) begin
            d.ch   = 7'(glyphs[found[k]]);
            d.last = (k == 0);
            digits_due.push_back(d);
         end
      endfunction

      task report(string what);
         if (fail_count < PRINT_LIMIT)
            $display("%0t ERROR: %s", $time, what);
         fail_count++;
      endtask

      task check_digit(logic [6:0] ch, logic last);
         digit_type want;
         if (digits_due.size() == 0) begin
            report($sformatf("unexpected digit transfer char %02h last %0b", ch, last));
            return;
         end
         want = digits_due.pop_front();
         if (ch !== want.ch)
            report($sformatf("digit char %02h, want %02h", ch, want.ch));
         if (last !== want.last)
            report($sformatf("last flag %0b, want %0b", last, want.last));
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [VALUE_PORT_W-1:0] req_value;
   logic [2:0]              req_format;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [6:0]              rsp_digit_char;
   logic                    rsp_last;

   digit_scoreboard sb = new();
   bit              sender_idles   = 1'b1;
   bit              receiver_idles = 1'b1;
   int              quiet_cycles   = 0;

   integer_to_ascii_radix u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .req_format     (req_format),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   always #5 clock = ~clock;

   task automatic send_number(logic [VALUE_PORT_W-1:0] v, logic [2:0] f);
      int gap;
      gap = sender_idles ? $urandom_range(0, 8) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_value  <= v;
      req_format <= f;
      do @(posedge clock); while (req_stall);
      sb.note_request(v, f);
   endtask

   // drop valid first so the last transfer is not taken again
   task automatic wait_all_digits();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.digits_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [VALUE_PORT_W-1:0] pick_value();
      logic [VALUE_PORT_W-1:0] v;
      case ($urandom_range(0, 5))
         0: v = {$urandom, $urandom};
         1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
         2: v = 64'($urandom_range(0, 20));
         3: v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
         4: v = ~({$urandom, $urandom} >> $urandom_range(0, 63));
         default: begin
            v = 64'd1;
            repeat ($urandom_range(0, 19)) v = v * 64'd10;
            v = v - 64'($urandom_range(0, 1));
         end
      endcase
      return v;
   endfunction

   function automatic logic [2:0] pick_format();
      int r;
      r = $urandom_range(0, 14);
      return (r < 12) ? 3'(r % 5) : 3'(5 + r % 3);
   endfunction

   // receiving side
   initial begin
      int gap;
      rsp_stall = 1'b0;
      forever begin
         gap = receiver_idles ? $urandom_range(0, 8) : 0;
         if (gap != 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_digit(rsp_digit_char, rsp_last);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("integer_to_ascii_radix verification failed");
            $finish;
         end
      end
   end

   initial begin
      req_valid  = 1'b0;
      req_value  = '0;
      req_format = FMT_UDEC;
      reset      = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero and all-ones in every format
      send_number(64'd0, FMT_UDEC);
      send_number(64'd0, FMT_OCT);
      send_number(64'd0, FMT_LHEX);
      send_number(64'd0, FMT_UHEX);
      send_number(64'd0, FMT_SDEC);
      send_number('1, FMT_UDEC);
      send_number('1, FMT_OCT);
      send_number('1, FMT_LHEX);
      send_number('1, FMT_UHEX);
      send_number('1, FMT_SDEC);
      // most negative and most positive signed values
      send_number(64'h8000_0000_0000_0000, FMT_SDEC);
      send_number(64'h8000_0000_0000_0000, FMT_OCT);
      send_number(64'h7fff_ffff_ffff_ffff, FMT_SDEC);
      // unused codes fall back to unsigned decimal, then one value in both hex cases
      send_number(64'hfedc_ba98_7654_3210, 3'd5);
      send_number(64'd1234567890, 3'd6);
      send_number(64'h8000_0000_0000_0001, 3'd7);
      send_number(64'habcd_ef01_2345_6789, FMT_LHEX);
      send_number(64'habcd_ef01_2345_6789, FMT_UHEX);
      // radix boundaries
      send_number(64'd9, FMT_UDEC);
      send_number(64'd10, FMT_UDEC);
      send_number(64'd99, FMT_SDEC);
      send_number(64'd7, FMT_OCT);
      send_number(64'd8, FMT_OCT);
      send_number(64'd15, FMT_LHEX);
      send_number(64'd16, FMT_UHEX);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % PHASE_ITEMS == 0) begin
            // hold off until the converter has drained, then change idling
            wait_all_digits();
            sender_idles   = ((i / PHASE_ITEMS) % 4) inside {0, 2};
            receiver_idles = ((i / PHASE_ITEMS) % 4) inside {0, 1};
         end
         send_number(pick_value(), pick_format());
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait_all_digits();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.fail_count == 0)
         $display("integer_to_ascii_radix verification clean");
      else
         $display("integer_to_ascii_radix verification failed");
      $finish;
   end
endmodule
`default_nettype wire
